### hw/rtl/esd_pkg.sv
// ----------------------------------------------------------------------------
// Escape decoder package
// Shared widths, character codes, result kinds and transaction structures.
// ----------------------------------------------------------------------------
package esd_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned LEN_W     = 11;
	localparam int unsigned MAX_BYTES = 1024;

	localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0] CH_THREE  = 8'h33;
	localparam logic [CH_W-1:0] CH_SEVEN  = 8'h37;
	localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CH_W-1:0] CH_LOW_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LOW_F  = 8'h66;
	localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_F   = 8'h46;
	localparam logic [CH_W-1:0] CH_LOW_X  = 8'h78;

	localparam logic [LEN_W-1:0] CAP_MAX     = LEN_W'(MAX_BYTES);
	localparam logic [LEN_W-1:0] CFG_DEFAULT = LEN_W'(1024);

	// KIND_BYTE doubles as "no error" in the error register.
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_BAD  = 2'd2,
		KIND_LONG = 2'd3
	} kind_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            is_end;
	} char_item_t;

	typedef struct packed {
		logic [CH_W-1:0]  data_byte;
		kind_t            kind;
		logic [LEN_W-1:0] length;
	} result_t;

endpackage

### hw/rtl/esd_if.sv
// ----------------------------------------------------------------------------
// Escape decoder channel interfaces
// Valid/ready channels for input characters and for decoded results.
// ----------------------------------------------------------------------------
interface esd_char_if import esd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            is_end;

	modport source (output valid, ch, is_end, input ready);
	modport sink   (input valid, ch, is_end, output ready);
endinterface

interface esd_res_if import esd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  data_byte;
	kind_t            kind;
	logic [LEN_W-1:0] length;

	modport source (output valid, data_byte, kind, length, input ready);
	modport sink   (input valid, data_byte, kind, length, output ready);
endinterface

### hw/rtl/esd_in_stage.sv
// ----------------------------------------------------------------------------
// Escape decoder input stage
// Registers one input transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module esd_in_stage import esd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	esd_char_if.sink    in,
	input  logic        take,
	output logic        valid_s1,
	output char_item_t  item_s1
);

	assign in.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			item_s1.ch     <= in.ch;
			item_s1.is_end <= in.is_end;
		end
	end

endmodule

### hw/rtl/esd_core.sv
// ----------------------------------------------------------------------------
// Escape decoder core
// Parses one registered character per cycle unless a pending result blocks it, and writes the result register.
// ----------------------------------------------------------------------------
module esd_core import esd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  char_item_t       item_s1,
	input  logic [LEN_W-1:0] max_length,
	output logic             take,
	esd_res_if.source        out
);

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_ESCAPE = 3'd1,
		M_OCT2   = 3'd2,
		M_OCT3   = 3'd3,
		M_HEX1   = 3'd4,
		M_HEX2   = 3'd5,
		M_SKIP   = 3'd6
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [CH_W-1:0]  part_q, part_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	kind_t            err_q, err_d;
	logic             res_valid_q;
	result_t          res_q, res_d;
	logic             res_gen;
	logic             emit;
	logic             fail;
	logic [CH_W-1:0]  emit_val;
	logic [LEN_W-1:0] cap;
	logic [4:0]       hex;
	logic             oct_ok;
	logic             out_free;

	function automatic logic [4:0] hex_decode(input logic [CH_W-1:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	assign cap      = (max_length > CAP_MAX) ? CAP_MAX : max_length;
	assign hex      = hex_decode(item_s1.ch);
	assign oct_ok   = (item_s1.ch >= CH_ZERO) && (item_s1.ch <= CH_SEVEN);
	assign out_free = !res_valid_q || out.ready;

	always_comb begin
		mode_d   = mode_q;
		part_d   = part_q;
		cnt_d    = cnt_q;
		err_d    = err_q;
		res_gen  = 1'b0;
		res_d    = '0;
		emit     = 1'b0;
		fail     = 1'b0;
		emit_val = item_s1.ch;
		if (item_s1.is_end) begin
			res_gen = 1'b1;
			if (err_q == KIND_LONG) begin
				res_d.kind = KIND_LONG;
			end else if (err_q == KIND_BAD || mode_q != M_NORMAL) begin
				res_d.kind   = KIND_BAD;
				res_d.length = cnt_q;
			end else begin
				res_d.kind   = KIND_DONE;
				res_d.length = cnt_q;
			end
			mode_d = M_NORMAL;
			part_d = '0;
			cnt_d  = '0;
			err_d  = KIND_BYTE;
		end else begin
			unique case (mode_q)
				M_NORMAL: begin
					if (item_s1.ch == CH_BSLASH) begin
						mode_d = M_ESCAPE;
					end else begin
						emit = 1'b1;
					end
				end
				M_ESCAPE: begin
					if (item_s1.ch == CH_BSLASH || item_s1.ch == CH_QUOTE) begin
						emit = 1'b1;
					end else if (item_s1.ch >= CH_ZERO && item_s1.ch <= CH_THREE) begin
						part_d = {6'b0, item_s1.ch[1:0]};
						mode_d = M_OCT2;
					end else if (item_s1.ch == CH_LOW_X) begin
						part_d = '0;
						mode_d = M_HEX1;
					end else begin
						fail = 1'b1;
					end
				end
				M_OCT2: begin
					if (oct_ok) begin
						part_d = {part_q[4:0], item_s1.ch[2:0]};
						mode_d = M_OCT3;
					end else begin
						fail = 1'b1;
					end
				end
				M_OCT3: begin
					emit_val = {part_q[4:0], item_s1.ch[2:0]};
					emit     = oct_ok;
					fail     = !oct_ok;
				end
				M_HEX1: begin
					if (hex[4]) begin
						part_d = {4'b0, hex[3:0]};
						mode_d = M_HEX2;
					end else begin
						fail = 1'b1;
					end
				end
				M_HEX2: begin
					emit_val = {part_q[3:0], hex[3:0]};
					emit     = hex[4];
					fail     = !hex[4];
				end
				M_SKIP: begin
					mode_d = M_SKIP;
				end
				default: begin
					mode_d = M_SKIP;
				end
			endcase
			if (emit) begin
				mode_d = M_NORMAL;
				part_d = '0;
				if (cnt_q >= cap) begin
					err_d  = KIND_LONG;
					mode_d = M_SKIP;
				end else begin
					cnt_d           = cnt_q + LEN_W'(1);
					res_gen         = 1'b1;
					res_d.data_byte = emit_val;
					res_d.kind      = KIND_BYTE;
				end
			end
			if (fail) begin
				err_d  = KIND_BAD;
				mode_d = M_SKIP;
			end
		end
	end

	assign take = valid_s1 && (out_free || !res_gen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_NORMAL;
			part_q      <= '0;
			cnt_q       <= '0;
			err_q       <= KIND_BYTE;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= mode_d;
				part_q <= part_d;
				cnt_q  <= cnt_d;
				err_q  <= err_d;
			end
			if (out_free) begin
				res_valid_q <= take && res_gen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && take && res_gen) begin
			res_q <= res_d;
		end
	end

	assign out.valid     = res_valid_q;
	assign out.data_byte = res_q.data_byte;
	assign out.kind      = res_q.kind;
	assign out.length    = res_q.length;

	a_err_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != KIND_BYTE) |-> (mode_q == M_SKIP))
		else $error("error recorded but parser not skipping");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_MAX)
		else $error("byte count beyond buffer capacity");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item_s1.is_end) |=> (mode_q == M_NORMAL && cnt_q == '0 && err_q == KIND_BYTE))
		else $error("end marker did not clear string state");

	a_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.kind == KIND_LONG) |-> (res_q.length == '0))
		else $error("too-long result carries a length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !out.ready) |=> (res_valid_q && $stable(res_q)))
		else $error("pending result lost or changed");

endmodule

### hw/rtl/escaped_string_to_bytes.sv
// ----------------------------------------------------------------------------
// Escaped string to bytes decoder
// Decodes a character stream with C-style escapes into raw bytes and status.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  in        sink       ch[7:0], is_end
//  out       source     data_byte[7:0], kind[1:0], length[10:0]
//  cfg       write      cfg_wr_en, cfg_wr_data[10:0] (max_length)
//
// One character is accepted per cycle unless the output stalls; its result is
// presented once it has passed from the input register to the result register.
// The parser state updates once per character.
// Reset clears the parser state and sets max_length to 1024.
// A stalled output holds its result while one more character waits in the input
// register; input stalls only when that character would produce a result too.
// ----------------------------------------------------------------------------
module escaped_string_to_bytes import esd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	esd_char_if.sink         in,
	esd_res_if.source        out,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data
);

	logic [LEN_W-1:0] max_length_q;
	logic             take;
	logic             valid_s1;
	char_item_t       item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= CFG_DEFAULT;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	esd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (in),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	esd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.max_length (max_length_q),
		.take       (take),
		.out        (out)
	);

endmodule
